/* sv/particle_sensor_frame_receiver_macros.svh */
// ============================================================================
// Particle sensor frame receiver assertion macros
// Shorthand for clocked assertions that are disabled while reset is low.
// ============================================================================
`ifndef PARTICLE_SENSOR_FRAME_RECEIVER_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_RECEIVER_MACROS_SVH

// General form with explicit clock and active-low reset.
`define PSFR_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Form used inside modules whose clock and reset are i_clk and i_rst_n.
`define PSFR_ASSERT(lbl, prop, msg) \
    `PSFR_ASSERT_IMPL(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* sv/psfr_pkg.sv */
// ============================================================================
// Particle sensor frame receiver package
// Shared widths, codes, types and helper functions.
// ============================================================================
package psfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int LEN_W            = 8;

    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int WIDX_W   = 4;
    localparam int WORD_W   = 16;
    localparam int TIMER_W  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [KIND_W-1:0]   t_kind;

    localparam t_opcode OP_BYTE = 2'd0;
    localparam t_opcode OP_TICK = 2'd1;
    localparam t_opcode OP_READ = 2'd2;

    localparam t_status STAT_NONE    = 2'd0;
    localparam t_status STAT_VALID   = 2'd1;
    localparam t_status STAT_INVALID = 2'd2;

    localparam t_kind KIND_NONE  = 2'd0;
    localparam t_kind KIND_L28   = 2'd1;
    localparam t_kind KIND_L20   = 2'd2;
    localparam t_kind KIND_OTHER = 2'd3;

    localparam logic [BYTE_W-1:0]  HDR0        = 8'h42;
    localparam logic [BYTE_W-1:0]  HDR1        = 8'h4D;
    localparam logic [WORD_W-1:0]  LEN_FULL    = 16'd28;
    localparam logic [WORD_W-1:0]  LEN_SHORT   = 16'd20;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd20;

    localparam int NUM_WORDS   = 12;
    localparam int WORDS_SHORT = 6;
    localparam int DATA_OFS    = 4;

    localparam logic [WIDX_W-1:0] LAST_WORD_IDX = 4'd11;

    localparam int POS_HDR0   = 0;
    localparam int POS_HDR1   = 1;
    localparam int POS_LEN_HI = 2;
    localparam int POS_LEN_LO = 3;

    typedef struct packed {
        logic             pending;
        logic             frame_ok;
        logic [LEN_W-1:0] len;
        t_kind            kind;
    } t_read_req;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_RD,
        BS_ACC,
        BS_SEND
    } t_back_state;

    typedef enum logic [2:0] {
        PH_SUM,
        PH_CK_HI,
        PH_CK_LO,
        PH_W_HI,
        PH_W_LO
    } t_walk_phase;

    function automatic logic [WIDX_W-1:0] words_for_kind(input t_kind fkind);
        logic [WIDX_W-1:0] n;
        case (fkind)
            KIND_L28: n = WIDX_W'(NUM_WORDS);
            KIND_L20: n = WIDX_W'(WORDS_SHORT);
            default:  n = '0;
        endcase
        return n;
    endfunction

endpackage

/* sv/psfr_if.sv */
// ============================================================================
// Particle sensor frame receiver channel interfaces
// Valid/ready channels for input items, result items and the register write.
// ============================================================================
interface psfr_in_if;
    import psfr_pkg::*;

    logic               valid;
    logic               ready;
    t_opcode            opcode;
    logic [BYTE_W-1:0]  rx_byte;

    modport source(output valid, output opcode, output rx_byte, input ready);
    modport sink(input valid, input opcode, input rx_byte, output ready);
endinterface

interface psfr_out_if;
    import psfr_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    t_kind              frame_kind;
    logic [WIDX_W-1:0]  word_index;
    logic [WORD_W-1:0]  word_value;
    logic               last;

    modport source(output valid, output status, output frame_kind, output word_index,
                   output word_value, output last, input ready);
    modport sink(input valid, input status, input frame_kind, input word_index,
                 input word_value, input last, output ready);
endinterface

interface psfr_cfg_if;
    import psfr_pkg::*;

    logic               valid;
    logic               ready;
    logic [TIMER_W-1:0] gap_timeout_ticks;

    modport source(output valid, output gap_timeout_ticks, input ready);
    modport sink(input valid, input gap_timeout_ticks, output ready);
endinterface

/* sv/psfr_ram.sv */
// ============================================================================
// Particle sensor frame receiver RAM
// Generic single-write, single-read memory with registered read data.
// ============================================================================
module psfr_ram #(
    parameter int WIDTH = psfr_pkg::BYTE_W,
    parameter int DEPTH = psfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* sv/psfr_queue.sv */
// ============================================================================
// Particle sensor frame receiver request queue
// Two-entry queue carrying classified read requests to the back end.
// ============================================================================
module psfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  psfr_pkg::t_read_req i_push_data,
    output logic                o_full,
    output logic                o_valid,
    output psfr_pkg::t_read_req o_data,
    input  logic                i_pop
);
    import psfr_pkg::*;

    t_read_req          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end
endmodule

/* sv/psfr_front.sv */
// ============================================================================
// Particle sensor frame receiver front end
// Accepts items, stores bytes, runs the gap timer and classifies reads.
// ============================================================================
module psfr_front #(
    parameter int BUFFER_DEPTH = psfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    psfr_in_if.sink                           i_in,
    psfr_cfg_if.sink                          i_cfg,
    input  logic                              i_store_busy,
    input  logic                              i_req_ready,
    output logic                              o_req_valid,
    output psfr_pkg::t_read_req               o_req,
    output logic                              o_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]   o_wr_addr,
    output logic [psfr_pkg::BYTE_W-1:0]       o_wr_data,
    output logic [BUFFER_DEPTH-1:0]           o_entry_vld
);
    import psfr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = AW + 1;

    logic [TIMER_W-1:0]      r_timeout, n_timeout;
    logic [TIMER_W-1:0]      r_timer, n_timer;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_pending, n_pending;
    logic [BUFFER_DEPTH-1:0] r_entry_vld, n_entry_vld;
    logic [BYTE_W-1:0]       r_hdr0, n_hdr0;
    logic [BYTE_W-1:0]       r_hdr1, n_hdr1;
    logic [BYTE_W-1:0]       r_len_hi, n_len_hi;
    logic [BYTE_W-1:0]       r_len_lo, n_len_lo;

    logic                    w_accept;
    logic [WORD_W-1:0]       w_len;
    logic                    w_len_fits;
    logic                    w_hdr_ok;

    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_len       = {r_len_hi, r_len_lo};
    assign w_len_fits  = (({1'b0, w_len} + 17'd3) < 17'(BUFFER_DEPTH));
    assign w_hdr_ok    = (r_hdr0 == HDR0) && (r_hdr1 == HDR1);

    always_comb begin
        case (i_in.opcode)
            OP_BYTE: i_in.ready = !i_store_busy;
            OP_READ: i_in.ready = i_req_ready;
            default: i_in.ready = 1'b1;
        endcase
    end

    assign o_wr_en     = w_accept && (i_in.opcode == OP_BYTE) && !r_pending
                         && (r_count < CW'(BUFFER_DEPTH));
    assign o_wr_addr   = r_count[AW-1:0];
    assign o_wr_data   = i_in.rx_byte;
    assign o_entry_vld = r_entry_vld;

    assign o_req_valid    = w_accept && (i_in.opcode == OP_READ);
    assign o_req.pending  = r_pending;
    assign o_req.frame_ok = w_hdr_ok && w_len_fits;
    assign o_req.len      = w_len[LEN_W-1:0];
    assign o_req.kind     = (w_len == LEN_FULL)  ? KIND_L28 :
                            (w_len == LEN_SHORT) ? KIND_L20 : KIND_OTHER;

    always_comb begin
        n_timeout   = r_timeout;
        n_timer     = r_timer;
        n_count     = r_count;
        n_pending   = r_pending;
        n_entry_vld = r_entry_vld;
        n_hdr0      = r_hdr0;
        n_hdr1      = r_hdr1;
        n_len_hi    = r_len_hi;
        n_len_lo    = r_len_lo;
        if (i_cfg.valid) begin
            n_timeout = i_cfg.gap_timeout_ticks;
        end
        if (w_accept) begin
            case (i_in.opcode)
                OP_BYTE: begin
                    if (!r_pending) begin
                        n_timer = r_timeout;
                    end
                    if (o_wr_en) begin
                        n_count                = r_count + 1'b1;
                        n_entry_vld[o_wr_addr] = 1'b1;
                        if (o_wr_addr == AW'(POS_HDR0)) begin
                            n_hdr0 = o_wr_data;
                        end
                        if (o_wr_addr == AW'(POS_HDR1)) begin
                            n_hdr1 = o_wr_data;
                        end
                        if (o_wr_addr == AW'(POS_LEN_HI)) begin
                            n_len_hi = o_wr_data;
                        end
                        if (o_wr_addr == AW'(POS_LEN_LO)) begin
                            n_len_lo = o_wr_data;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_timer != '0) begin
                        n_timer = r_timer - 1'b1;
                    end else begin
                        if ((r_count != '0) && w_hdr_ok) begin
                            n_pending = 1'b1;
                        end
                        n_count = '0;
                    end
                end
                OP_READ: begin
                    n_pending = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_timer     <= '0;
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_entry_vld <= '0;
            r_hdr0      <= '0;
            r_hdr1      <= '0;
            r_len_hi    <= '0;
            r_len_lo    <= '0;
        end else begin
            r_timeout   <= n_timeout;
            r_timer     <= n_timer;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_entry_vld <= n_entry_vld;
            r_hdr0      <= n_hdr0;
            r_hdr1      <= n_hdr1;
            r_len_hi    <= n_len_hi;
            r_len_lo    <= n_len_lo;
        end
    end
endmodule

/* sv/psfr_back.sv */
// ============================================================================
// Particle sensor frame receiver back end
// Walks the stored frame for the checksum and sends the result words.
// ============================================================================
module psfr_back #(
    parameter int BUFFER_DEPTH = psfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  psfr_pkg::t_read_req               i_req,
    output logic                              o_req_pop,
    output logic [$clog2(BUFFER_DEPTH)-1:0]   o_rd_addr,
    input  logic [psfr_pkg::BYTE_W-1:0]       i_rd_data,
    input  logic [BUFFER_DEPTH-1:0]           i_entry_vld,
    output logic                              o_busy,
    psfr_out_if.source                        o_out
);
    import psfr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    t_back_state        r_state, n_state;
    t_walk_phase        r_phase, n_phase;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_len, n_len;
    t_kind              r_kind, n_kind;
    logic [WORD_W-1:0]  r_sum, n_sum;
    logic [BYTE_W-1:0]  r_ck_hi, n_ck_hi;
    logic [BYTE_W-1:0]  r_word_hi, n_word_hi;
    logic [WIDX_W-1:0]  r_widx, n_widx;
    logic               r_rd_vld, n_rd_vld;
    t_status            r_o_status, n_o_status;
    t_kind              r_o_kind, n_o_kind;
    logic [WIDX_W-1:0]  r_o_widx, n_o_widx;
    logic [WORD_W-1:0]  r_o_value, n_o_value;
    logic               r_o_last, n_o_last;

    assign o_rd_addr        = r_addr;
    assign o_busy           = (r_state != BS_IDLE);
    assign o_out.valid      = (r_state == BS_SEND);
    assign o_out.status     = r_o_status;
    assign o_out.frame_kind = r_o_kind;
    assign o_out.word_index = r_o_widx;
    assign o_out.word_value = r_o_value;
    assign o_out.last       = r_o_last;

    always_comb begin
        logic              v_start_word;
        logic [WIDX_W-1:0] v_k;
        logic              v_short;
        t_status           v_short_status;
        logic [BYTE_W-1:0] v_byte;

        n_state        = r_state;
        n_phase        = r_phase;
        n_addr         = r_addr;
        n_len          = r_len;
        n_kind         = r_kind;
        n_sum          = r_sum;
        n_ck_hi        = r_ck_hi;
        n_word_hi      = r_word_hi;
        n_widx         = r_widx;
        n_rd_vld       = r_rd_vld;
        n_o_status     = r_o_status;
        n_o_kind       = r_o_kind;
        n_o_widx       = r_o_widx;
        n_o_value      = r_o_value;
        n_o_last       = r_o_last;
        o_req_pop      = 1'b0;
        v_start_word   = 1'b0;
        v_k            = '0;
        v_short        = 1'b0;
        v_short_status = STAT_NONE;
        v_byte         = r_rd_vld ? i_rd_data : '0;

        case (r_state)
            BS_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_kind    = i_req.kind;
                    n_len     = i_req.len[AW-1:0];
                    if (!i_req.pending) begin
                        v_short        = 1'b1;
                        v_short_status = STAT_NONE;
                    end else if (!i_req.frame_ok) begin
                        v_short        = 1'b1;
                        v_short_status = STAT_INVALID;
                    end else begin
                        n_addr  = '0;
                        n_sum   = '0;
                        n_phase = PH_SUM;
                        n_state = BS_RD;
                    end
                end
            end
            BS_RD: begin
                n_rd_vld = i_entry_vld[r_addr];
                n_state  = BS_ACC;
            end
            BS_ACC: begin
                n_state = BS_RD;
                case (r_phase)
                    PH_SUM: begin
                        n_sum  = r_sum + WORD_W'(v_byte);
                        n_addr = r_addr + 1'b1;
                        if (r_addr == r_len + 1'b1) begin
                            n_phase = PH_CK_HI;
                        end
                    end
                    PH_CK_HI: begin
                        n_ck_hi = v_byte;
                        n_addr  = r_addr + 1'b1;
                        n_phase = PH_CK_LO;
                    end
                    PH_CK_LO: begin
                        if ({r_ck_hi, v_byte} == r_sum) begin
                            v_start_word = 1'b1;
                            v_k          = '0;
                        end else begin
                            v_short        = 1'b1;
                            v_short_status = STAT_INVALID;
                        end
                    end
                    PH_W_HI: begin
                        n_word_hi = v_byte;
                        n_addr    = r_addr + 1'b1;
                        n_phase   = PH_W_LO;
                    end
                    PH_W_LO: begin
                        n_o_status = STAT_VALID;
                        n_o_kind   = r_kind;
                        n_o_widx   = r_widx;
                        n_o_value  = {r_word_hi, v_byte};
                        n_o_last   = (r_widx == LAST_WORD_IDX);
                        n_state    = BS_SEND;
                    end
                    default: begin
                        n_state = BS_IDLE;
                    end
                endcase
            end
            BS_SEND: begin
                if (o_out.ready) begin
                    if (r_o_last) begin
                        n_state = BS_IDLE;
                    end else begin
                        v_start_word = 1'b1;
                        v_k          = WIDX_W'(r_widx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase

        if (v_short) begin
            n_o_status = v_short_status;
            n_o_kind   = KIND_NONE;
            n_o_widx   = '0;
            n_o_value  = '0;
            n_o_last   = 1'b1;
            n_state    = BS_SEND;
        end

        if (v_start_word) begin
            n_widx = v_k;
            if (v_k < words_for_kind(r_kind)) begin
                n_addr  = AW'(DATA_OFS) + AW'({v_k, 1'b0});
                n_phase = PH_W_HI;
                n_state = BS_RD;
            end else begin
                n_o_status = STAT_VALID;
                n_o_kind   = r_kind;
                n_o_widx   = v_k;
                n_o_value  = '0;
                n_o_last   = (v_k == LAST_WORD_IDX);
                n_state    = BS_SEND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase    <= n_phase;
        r_addr     <= n_addr;
        r_len      <= n_len;
        r_kind     <= n_kind;
        r_sum      <= n_sum;
        r_ck_hi    <= n_ck_hi;
        r_word_hi  <= n_word_hi;
        r_widx     <= n_widx;
        r_rd_vld   <= n_rd_vld;
        r_o_status <= n_o_status;
        r_o_kind   <= n_o_kind;
        r_o_widx   <= n_o_widx;
        r_o_value  <= n_o_value;
        r_o_last   <= n_o_last;
    end
endmodule

/* sv/particle_sensor_frame_receiver.sv */
// ============================================================================
// Particle sensor frame receiver
// Byte and tick requests never produce results; a register write is taken
// in the cycle it is offered. A read request is classified by the front end
// and queued (two entries) for the back end, which answers an empty or
// malformed frame with one result. A frame that passes the header and
// length checks is walked through the single read port of the frame
// memory, one byte at a time over L+4 bytes for the checksum; then each
// present data word is read as a high and a low byte before its result,
// each absent word is sent as zero with no read, and each result is held
// while the result channel stalls. Byte requests are held off while a read
// is queued or in progress so the stored frame stays intact; ticks keep
// flowing. The frame memory carries one valid flag per entry, cleared by
// reset, so no clearing pass is needed after reset.
// ============================================================================
module particle_sensor_frame_receiver #(
    parameter int BUFFER_DEPTH = psfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psfr_in_if.sink     i_in,
    psfr_cfg_if.sink    i_cfg,
    psfr_out_if.source  o_out
);
    import psfr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic                    w_req_push;
    t_read_req               w_req_push_data;
    logic                    w_q_full;
    logic                    w_q_valid;
    t_read_req               w_q_data;
    logic                    w_q_pop;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic [BYTE_W-1:0]       w_wr_data;
    logic [AW-1:0]           w_rd_addr;
    logic [BYTE_W-1:0]       w_rd_data;
    logic [BUFFER_DEPTH-1:0] w_entry_vld;
    logic                    w_back_busy;
    logic                    w_store_busy;

    assign w_store_busy = w_back_busy || w_q_valid;

    psfr_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_store_busy (w_store_busy),
        .i_req_ready  (!w_q_full),
        .o_req_valid  (w_req_push),
        .o_req        (w_req_push_data),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_entry_vld  (w_entry_vld)
    );

    psfr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_req_push),
        .i_push_data (w_req_push_data),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .i_pop       (w_q_pop)
    );

    psfr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(BUFFER_DEPTH)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    psfr_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_q_valid),
        .i_req       (w_q_data),
        .o_req_pop   (w_q_pop),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .i_entry_vld (w_entry_vld),
        .o_busy      (w_back_busy),
        .o_out       (o_out)
    );
endmodule

/* sv/psfr_checker.sv */
// ============================================================================
// Particle sensor frame receiver checker
// Port-level checks on the result channel, bound to the top level.
// ============================================================================
`include "particle_sensor_frame_receiver_macros.svh"

module psfr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  psfr_pkg::t_status           i_out_status,
    input  psfr_pkg::t_kind             i_out_frame_kind,
    input  logic [psfr_pkg::WIDX_W-1:0] i_out_word_index,
    input  logic [psfr_pkg::WORD_W-1:0] i_out_word_value,
    input  logic                        i_out_last
);
    import psfr_pkg::*;

    logic                                   w_stall;
    logic                                   w_data_res;
    logic                                   w_short_res;
    logic                                   w_short_ok;
    logic                                   w_last_ok;
    logic                                   w_absent;
    logic                                   w_step;
    logic [STATUS_W+KIND_W+WIDX_W+WORD_W:0] w_payload;
    logic [WIDX_W-1:0]                      r_idx_next;

    assign w_stall     = i_out_valid && !i_out_ready;
    assign w_data_res  = i_out_valid && (i_out_status == STAT_VALID);
    assign w_short_res = i_out_valid && (i_out_status != STAT_VALID);
    assign w_payload   = {i_out_status, i_out_frame_kind, i_out_word_index,
                          i_out_word_value, i_out_last};
    assign w_short_ok  = i_out_last && (i_out_word_index == '0) && (i_out_word_value == '0)
                         && (i_out_frame_kind == KIND_NONE);
    assign w_last_ok   = (i_out_last == (i_out_word_index == LAST_WORD_IDX))
                         && (i_out_frame_kind != KIND_NONE);
    assign w_absent    = w_data_res && ((i_out_frame_kind == KIND_OTHER)
                         || ((i_out_frame_kind == KIND_L20)
                             && (i_out_word_index >= WIDX_W'(WORDS_SHORT))));
    assign w_step      = w_data_res && i_out_ready && !i_out_last;

    always_ff @(posedge i_clk) begin
        r_idx_next <= i_out_word_index + 1'b1;
    end

    `PSFR_ASSERT(a_out_hold, w_stall |=> i_out_valid && $stable(w_payload), "Result not held.")

    `PSFR_ASSERT(a_short_result, w_short_res |-> w_short_ok, "Single result carries data.")

    `PSFR_ASSERT(a_last_on_final, w_data_res |-> w_last_ok, "Last flag misplaced.")

    `PSFR_ASSERT(a_absent_zero, w_absent |-> (i_out_word_value == '0), "Absent word not zero.")

    `PSFR_ASSERT(a_index_step, w_step |=> !i_out_valid || (i_out_word_index == r_idx_next), "Index skipped.")
endmodule

bind particle_sensor_frame_receiver psfr_checker u_psfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_status     (o_out.status),
    .i_out_frame_kind (o_out.frame_kind),
    .i_out_word_index (o_out.word_index),
    .i_out_word_value (o_out.word_value),
    .i_out_last       (o_out.last)
);

/* sim/psfr_result_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// Particle sensor frame receiver result checker
// Watches the request, register and result channels. It keeps its own copy
// of the frame store, byte count, gap timer and pending flag, works out the
// data words that each read request must return, and compares every
// accepted result field by field with the oldest outstanding prediction.
// ============================================================================
module psfr_result_checker #(
    parameter int DEPTH = psfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    psfr_in_if   i_req,
    psfr_cfg_if  i_cfg,
    psfr_out_if  i_res,
    output int   o_fail_count,
    output int   o_open_results
);
    import psfr_pkg::*;

    typedef struct packed {
        t_status           status;
        t_kind             kind;
        logic [WIDX_W-1:0] idx;
        logic [WORD_W-1:0] value;
        logic              last;
    } t_word_result;

    logic [BYTE_W-1:0]  frame_mem [DEPTH];
    int unsigned        held_bytes;
    logic [TIMER_W-1:0] gap_left;
    logic [TIMER_W-1:0] gap_reload;
    logic               frame_ready;
    t_word_result       expected_words [$];
    t_word_result       got;
    t_word_result       want;
    int                 mismatches;

    function automatic logic [WORD_W-1:0] mem_word(int unsigned pos);
        return {frame_mem[pos], frame_mem[pos + 1]};
    endfunction

    function automatic logic frame_checks_out();
        logic [WORD_W-1:0] flen;
        logic [WORD_W-1:0] fsum;
        int unsigned       i;
        if (frame_mem[POS_HDR0] != HDR0 || frame_mem[POS_HDR1] != HDR1) begin
            return 1'b0;
        end
        flen = mem_word(POS_LEN_HI);
        if (int'(flen) + 3 >= DEPTH) begin
            return 1'b0;
        end
        fsum = '0;
        for (i = 0; i < int'(flen) + 2; i++) begin
            fsum = fsum + {8'h00, frame_mem[i]};
        end
        return fsum == mem_word(int'(flen) + 2);
    endfunction

    task automatic push_expected(t_status st, t_kind kind, int unsigned idx,
                                 logic [WORD_W-1:0] value, logic last);
        t_word_result w;
        w.status = st;
        w.kind   = kind;
        w.idx    = WIDX_W'(idx);
        w.value  = value;
        w.last   = last;
        expected_words.push_back(w);
    endtask

    task automatic predict_request(t_opcode op, logic [BYTE_W-1:0] rx);
        logic [WORD_W-1:0] flen;
        t_kind             kind;
        int unsigned       nwords;
        int unsigned       k;
        case (op)
            OP_BYTE: begin
                if (!frame_ready) begin
                    if (held_bytes < DEPTH) begin
                        frame_mem[held_bytes] = rx;
                        held_bytes++;
                    end
                    gap_left = gap_reload;
                end
            end
            OP_TICK: begin
                if (gap_left != '0) begin
                    gap_left = gap_left - 1'b1;
                end else begin
                    if (held_bytes != 0 && frame_mem[POS_HDR0] == HDR0 &&
                        frame_mem[POS_HDR1] == HDR1) begin
                        frame_ready = 1'b1;
                    end
                    held_bytes = 0;
                end
            end
            OP_READ: begin
                if (!frame_ready) begin
                    push_expected(STAT_NONE, KIND_NONE, 0, '0, 1'b1);
                end else begin
                    frame_ready = 1'b0;
                    if (!frame_checks_out()) begin
                        push_expected(STAT_INVALID, KIND_NONE, 0, '0, 1'b1);
                    end else begin
                        flen = mem_word(POS_LEN_HI);
                        if (flen == LEN_FULL) begin
                            kind   = KIND_L28;
                            nwords = NUM_WORDS;
                        end else if (flen == LEN_SHORT) begin
                            kind   = KIND_L20;
                            nwords = WORDS_SHORT;
                        end else begin
                            kind   = KIND_OTHER;
                            nwords = 0;
                        end
                        for (k = 0; k < NUM_WORDS; k++) begin
                            push_expected(STAT_VALID, kind, k,
                                          (k < nwords) ? mem_word(DATA_OFS + 2 * k) : '0,
                                          k == NUM_WORDS - 1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_mem[i]) begin
                frame_mem[i] = '0;
            end
            held_bytes  = 0;
            gap_left    = '0;
            gap_reload  = TIMEOUT_RST;
            frame_ready = 1'b0;
            expected_words.delete();
            mismatches  = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.status = i_res.status;
                got.kind   = i_res.frame_kind;
                got.idx    = i_res.word_index;
                got.value  = i_res.word_value;
                got.last   = i_res.last;
                if (expected_words.size() == 0) begin
                    $error("result with no outstanding request: word_index %0d, word_value %0h",
                           got.idx, got.value);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.kind !== want.kind) begin
                        $error("frame_kind: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("word_index: expected %0d, got %0d", want.idx, got.idx);
                        mismatches++;
                    end
                    if (got.value !== want.value) begin
                        $error("word_value: expected %0h, got %0h", want.value, got.value);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                gap_reload = i_cfg.gap_timeout_ticks;
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.opcode, i_req.rx_byte);
            end
        end
        o_fail_count   <= mismatches;
        o_open_results <= expected_words.size();
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// Particle sensor frame receiver testbench
// Drives byte, tick and read requests and gap timeout writes into the
// receiver, with random idling on the request side and random stalls on the
// result side. A directed opening covers empty reads, the unused opcode,
// closing without a header, lengths beyond the buffer, bytes while a frame
// is pending, stale headers and a zero timeout; random well-formed frames
// with noise, corruption, truncation and overflow follow.
// ============================================================================
module tb;
    import psfr_pkg::*;

    localparam t_opcode OP_UNUSED     = 2'd3;
    localparam int      BUF_DEPTH     = BUFFER_DEPTH_DEF;
    localparam int      CYCLE_LIMIT   = 400000;
    localparam int      SETTLE_CYCLES = 20;
    localparam int      PHASE_ITEMS   = 20;

    logic               i_clk;
    logic               i_rst_n;
    int                 idle_pct;
    int                 stall_pct;
    int                 cycle_count;
    int                 fail_count;
    int                 open_results;
    int                 items_sent;
    logic [TIMER_W-1:0] cur_timeout;

    psfr_in_if  req_ch ();
    psfr_cfg_if cfg_ch ();
    psfr_out_if res_ch ();

    particle_sensor_frame_receiver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    psfr_result_checker #(
        .DEPTH (BUF_DEPTH)
    ) u_result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_ch),
        .i_cfg          (cfg_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_open_results (open_results)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** particle_sensor_frame_receiver: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    task automatic send_request(t_opcode op, logic [BYTE_W-1:0] rx);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.opcode  <= op;
        req_ch.rx_byte <= rx;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (open_results != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [TIMER_W-1:0] ticks);
        wait_drained();
        cfg_ch.valid             <= 1'b1;
        cfg_ch.gap_timeout_ticks <= ticks;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_timeout = ticks;
    endtask

    task automatic close_and_read();
        repeat (int'(cur_timeout) + 1) send_request(OP_TICK, rand_byte());
        send_request(OP_READ, rand_byte());
    endtask

    task automatic run_sequence();
        logic [BYTE_W-1:0] fbytes [$];
        logic [WORD_W-1:0] fsum;
        int unsigned       pick;
        int unsigned       len;
        int unsigned       n;
        int unsigned       pos;
        pick = $urandom_range(99);
        if (cur_timeout == '1 || pick >= 90) begin
            n = $urandom_range(3, 10);
            repeat (n) send_request(t_opcode'($urandom_range(3)), rand_byte());
        end else begin
            if (pick < 35) begin
                len = LEN_FULL;
            end else if (pick < 55) begin
                len = LEN_SHORT;
            end else if (pick < 70) begin
                do begin
                    len = $urandom_range(2, BUF_DEPTH - 4);
                end while (len == LEN_FULL || len == LEN_SHORT);
            end else begin
                len = $urandom_range(2, LEN_FULL);
            end
            fbytes = {HDR0, HDR1, BYTE_W'(len >> 8), BYTE_W'(len)};
            repeat (len - 2) fbytes.push_back(rand_byte());
            fsum = '0;
            foreach (fbytes[j]) begin
                fsum = fsum + {8'h00, fbytes[j]};
            end
            fbytes.push_back(fsum[15:8]);
            fbytes.push_back(fsum[7:0]);
            if (pick >= 70 && pick < 80) begin
                pos = $urandom_range(fbytes.size() - 1);
                fbytes[pos] = fbytes[pos] ^ BYTE_W'(1 << $urandom_range(7));
            end else if (pick >= 80 && pick < 85) begin
                n = $urandom_range(1, fbytes.size() - 1);
                fbytes = fbytes[0:n-1];
            end else if (pick >= 85) begin
                n = $urandom_range(BUF_DEPTH - fbytes.size() + 1,
                                   BUF_DEPTH - fbytes.size() + 8);
                repeat (n) fbytes.push_back(rand_byte());
            end
            foreach (fbytes[j]) begin
                send_request(OP_BYTE, fbytes[j]);
                if (cur_timeout != '0 && $urandom_range(7) == 0) begin
                    send_request(OP_TICK, rand_byte());
                end
            end
            repeat ($urandom_range(2)) send_request(OP_TICK, rand_byte());
            close_and_read();
            if ($urandom_range(3) == 0) begin
                send_request(OP_READ, rand_byte());
            end
        end
    endtask

    initial begin
        int                 phase_goal;
        logic [TIMER_W-1:0] ticks;
        cycle_count              = 0;
        items_sent               = 0;
        idle_pct                 = 0;
        stall_pct                = 0;
        cur_timeout              = TIMEOUT_RST;
        i_rst_n                  = 1'b0;
        req_ch.valid             = 1'b0;
        req_ch.opcode            = OP_BYTE;
        req_ch.rx_byte           = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.gap_timeout_ticks = '0;
        res_ch.ready             = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_READ, 8'h00);
        send_request(OP_UNUSED, 8'hFF);
        write_timeout('0);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, 8'hFF);
        send_request(OP_TICK, 8'hFF);
        send_request(OP_READ, 8'hFF);
        // The length field points past the end of the buffer.
        send_request(OP_BYTE, HDR0);
        send_request(OP_BYTE, HDR1);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, 8'(BUF_DEPTH - 3));
        send_request(OP_TICK, 8'h00);
        send_request(OP_BYTE, 8'hAA);
        send_request(OP_READ, 8'h00);
        // A single byte reuses the second header byte left from before.
        send_request(OP_BYTE, HDR0);
        send_request(OP_TICK, 8'h55);
        send_request(OP_READ, 8'h00);
        send_request(OP_TICK, 8'h00);
        send_request(OP_READ, 8'h00);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: ticks = 16'd1;
                1: ticks = 16'd3;
                2: ticks = '1;
                3: ticks = TIMER_W'($urandom_range(2));
                4: ticks = 16'd2;
                5: ticks = '0;
                6: ticks = TIMER_W'($urandom_range(4, 12));
                default: ticks = 16'd1;
            endcase
            write_timeout(ticks);
            idle_pct  = (p % 4 == 1) ? 69 : (p % 4 == 3) ? 33 : 0;
            stall_pct = (p % 4 == 2) ? 69 : (p % 4 == 3) ? 33 : 0;
            phase_goal = items_sent + ((ticks == '1) ? 15 : PHASE_ITEMS);
            if (ticks != '1) begin
                close_and_read();
            end
            while (items_sent < phase_goal) begin
                run_sequence();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("** particle_sensor_frame_receiver: PASSED **");
        end else begin
            $display("** particle_sensor_frame_receiver: FAILED **");
        end
        $finish;
    end

endmodule
